// ===== src/xxh64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the xxHash64 stream hasher.
// No dependencies; used by the top level.

package xxh64_pkg;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  localparam logic [5:0] AVAL_SHIFT1 = 6'd33;
  localparam logic [5:0] AVAL_SHIFT2 = 6'd29;
  localparam logic [5:0] AVAL_SHIFT3 = 6'd32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RND_A,
    ST_RND_B,
    ST_RND_C,
    ST_FIN,
    ST_CONV,
    ST_LEN,
    ST_DISP,
    ST_AV0,
    ST_AV1,
    ST_AV2,
    ST_AV3,
    ST_AV4
  } state_e;

  // What the shared round steps are working on
  typedef enum logic [2:0] {
    CTX_STRIPE,
    CTX_MERGE,
    CTX_TAIL8,
    CTX_TAIL4,
    CTX_TAIL1
  } ctx_e;

endpackage

`default_nettype wire

// ===== src/xxhash64_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the xxHash64 stream hasher: sequencer, lane state, output word.
// Depends on xxh64_pkg and xxh64_mul.

// Takes a message as little-endian 64-bit words and emits its 64-bit xxHash
// on the word marked last. A word that does not complete a 32-byte stripe and
// is not last is taken without a stall. Every 64-bit multiply runs on the one
// shared 3-step multiplier: issue, three steps, result. A word that completes
// a stripe is followed by 8 multiplies, two per lane. The last word adds the
// finishing sequence: 3 multiplies per merged lane and per tail word, 2 per
// 4-byte or single-byte piece, and 2 for the avalanche, plus the start of the
// finish, each of the 4 convergence terms when a stripe was seen, the length
// add, each tail dispatch and each of the 3 avalanche xor steps. in_stall_o is
// high while a word is being worked on; a finished hash waits in its output
// register and does not stop the next word from being taken.

module xxhash64_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic        last_i,
  input  wire logic [63:0] seed_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_o
);

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] n);
    return (v << n) | (v >> (7'd64 - {1'b0, n}));
  endfunction

  xxh64_pkg::state_e state_q, state_d;
  xxh64_pkg::ctx_e   ctx_q, ctx_d;

  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q  [4];
  logic [1:0]  fill_q, fill_d, k_q, k_d;
  logic [63:0] total_q, total_d, seed_q, seed_d;
  logic        seen_q, seen_d, inmsg_q, inmsg_d, last_q, last_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] w_q, w_d, h_q, h_d, v_q, v_d;
  logic        issued_q, issued_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;

  logic        accept;
  logic [3:0]  nb;
  logic [63:0] wm;
  logic [1:0]  fill_cur;
  logic        buf_we;
  logic [1:0]  buf_wa;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic [63:0] conv_term;
  logic [5:0]  rot_c;
  logic [63:0] mul_c, add_c;

  assign accept = in_valid_i && (state_q == xxh64_pkg::ST_IDLE);

  // Byte count and masking of the incoming word
  always_comb begin
    if (!last_i || (valid_bytes_i > 4'd8)) begin
      nb = 4'd8;
    end else begin
      nb = valid_bytes_i;
    end
    for (int j = 0; j < 8; j++) begin
      wm[8*j +: 8] = (4'(j) < nb) ? word_i[8*j +: 8] : 8'h00;
    end
  end

  assign fill_cur = inmsg_q ? fill_q : 2'd0;

  // Convergence term for lane k
  always_comb begin
    unique case (k_q)
      2'd0:    conv_term = rotl(lane_q[0], 6'd1);
      2'd1:    conv_term = rotl(lane_q[1], 6'd7);
      2'd2:    conv_term = rotl(lane_q[2], 6'd12);
      default: conv_term = rotl(lane_q[3], 6'd18);
    endcase
  end

  // Constants of the final round step per context
  always_comb begin
    case (ctx_q)
      xxh64_pkg::CTX_TAIL8: begin
        rot_c = 6'd27;
        mul_c = xxh64_pkg::PRIME1;
        add_c = xxh64_pkg::PRIME4;
      end
      xxh64_pkg::CTX_TAIL4: begin
        rot_c = 6'd23;
        mul_c = xxh64_pkg::PRIME2;
        add_c = xxh64_pkg::PRIME3;
      end
      xxh64_pkg::CTX_TAIL1: begin
        rot_c = 6'd11;
        mul_c = xxh64_pkg::PRIME1;
        add_c = 64'h0;
      end
      default: begin
        rot_c = 6'd0;
        mul_c = xxh64_pkg::PRIME1;
        add_c = xxh64_pkg::PRIME4;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    lane_d      = lane_q;
    fill_d      = fill_q;
    k_d         = k_q;
    total_d     = total_q;
    seed_d      = seed_q;
    seen_d      = seen_q;
    inmsg_d     = inmsg_q;
    last_d      = last_q;
    left_d      = left_q;
    w_d         = w_q;
    h_d         = h_q;
    v_d         = v_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    buf_we      = 1'b0;
    buf_wa      = fill_cur;
    mul_start   = 1'b0;
    mul_a       = 64'h0;
    mul_b       = 64'h0;

    unique case (state_q)
      xxh64_pkg::ST_IDLE: begin
        if (accept) begin
          if (!inmsg_q) begin
            seed_d    = seed_i;
            lane_d[0] = seed_i + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
            lane_d[1] = seed_i + xxh64_pkg::PRIME2;
            lane_d[2] = seed_i;
            lane_d[3] = seed_i - xxh64_pkg::PRIME1;
            seen_d    = 1'b0;
            total_d   = 64'(nb);
          end else begin
            total_d = total_q + 64'(nb);
          end
          inmsg_d = !last_i;
          last_d  = last_i;
          w_d     = wm;
          left_d  = (nb == 4'd8) ? 4'd0 : nb;
          fill_d  = fill_cur;
          if (nb == 4'd8) begin
            buf_we = 1'b1;
            fill_d = fill_cur + 2'd1;
          end
          if ((nb == 4'd8) && (fill_cur == 2'd3)) begin
            ctx_d   = xxh64_pkg::CTX_STRIPE;
            k_d     = 2'd0;
            state_d = xxh64_pkg::ST_RND_A;
          end else if (last_i) begin
            state_d = xxh64_pkg::ST_FIN;
          end
        end
      end

      // First multiply of a round step
      xxh64_pkg::ST_RND_A: begin
        case (ctx_q)
          xxh64_pkg::CTX_MERGE: begin
            mul_a = lane_q[k_q];
            mul_b = xxh64_pkg::PRIME2;
          end
          xxh64_pkg::CTX_TAIL4: begin
            mul_a = {32'h0, w_q[31:0]};
            mul_b = xxh64_pkg::PRIME1;
          end
          xxh64_pkg::CTX_TAIL1: begin
            mul_a = {56'h0, w_q[7:0]};
            mul_b = xxh64_pkg::PRIME5;
          end
          default: begin
            mul_a = buf_q[k_q];
            mul_b = xxh64_pkg::PRIME2;
          end
        endcase
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          v_d      = mul_p;
          if ((ctx_q == xxh64_pkg::CTX_TAIL4) || (ctx_q == xxh64_pkg::CTX_TAIL1)) begin
            state_d = xxh64_pkg::ST_RND_C;
          end else begin
            state_d = xxh64_pkg::ST_RND_B;
          end
        end
      end

      // Second multiply of a lane round
      xxh64_pkg::ST_RND_B: begin
        mul_a = rotl(((ctx_q == xxh64_pkg::CTX_STRIPE) ? lane_q[k_q] : 64'h0) + v_q, 6'd31);
        mul_b = xxh64_pkg::PRIME1;
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          if (ctx_q == xxh64_pkg::CTX_STRIPE) begin
            lane_d[k_q] = mul_p;
            if (k_q == 2'd3) begin
              seen_d  = 1'b1;
              fill_d  = 2'd0;
              state_d = last_q ? xxh64_pkg::ST_FIN : xxh64_pkg::ST_IDLE;
            end else begin
              k_d     = k_q + 2'd1;
              state_d = xxh64_pkg::ST_RND_A;
            end
          end else begin
            v_d     = mul_p;
            state_d = xxh64_pkg::ST_RND_C;
          end
        end
      end

      // Fold into the hash: h = rotl(h ^ v) * K + C
      xxh64_pkg::ST_RND_C: begin
        mul_a = rotl(h_q ^ v_q, rot_c);
        mul_b = mul_c;
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          h_d      = mul_p + add_c;
          case (ctx_q)
            xxh64_pkg::CTX_MERGE: begin
              if (k_q == 2'd3) begin
                state_d = xxh64_pkg::ST_LEN;
              end else begin
                k_d     = k_q + 2'd1;
                state_d = xxh64_pkg::ST_RND_A;
              end
            end
            xxh64_pkg::CTX_TAIL4: begin
              w_d     = w_q >> 32;
              left_d  = left_q - 4'd4;
              state_d = xxh64_pkg::ST_DISP;
            end
            xxh64_pkg::CTX_TAIL1: begin
              w_d     = w_q >> 8;
              left_d  = left_q - 4'd1;
              state_d = xxh64_pkg::ST_DISP;
            end
            default: begin
              k_d     = k_q + 2'd1;
              state_d = xxh64_pkg::ST_DISP;
            end
          endcase
        end
      end

      xxh64_pkg::ST_FIN: begin
        k_d = 2'd0;
        if (seen_q) begin
          state_d = xxh64_pkg::ST_CONV;
        end else begin
          h_d     = seed_q + xxh64_pkg::PRIME5;
          state_d = xxh64_pkg::ST_LEN;
        end
      end

      // Lane convergence, one term a cycle
      xxh64_pkg::ST_CONV: begin
        h_d = ((k_q == 2'd0) ? 64'h0 : h_q) + conv_term;
        if (k_q == 2'd3) begin
          k_d     = 2'd0;
          ctx_d   = xxh64_pkg::CTX_MERGE;
          state_d = xxh64_pkg::ST_RND_A;
        end else begin
          k_d = k_q + 2'd1;
        end
      end

      xxh64_pkg::ST_LEN: begin
        h_d     = h_q + total_q;
        k_d     = 2'd0;
        state_d = xxh64_pkg::ST_DISP;
      end

      // Pick the next tail piece
      xxh64_pkg::ST_DISP: begin
        state_d = xxh64_pkg::ST_RND_A;
        if (k_q < fill_q) begin
          ctx_d = xxh64_pkg::CTX_TAIL8;
        end else if (left_q >= 4'd4) begin
          ctx_d = xxh64_pkg::CTX_TAIL4;
        end else if (left_q != 4'd0) begin
          ctx_d = xxh64_pkg::CTX_TAIL1;
        end else begin
          state_d = xxh64_pkg::ST_AV0;
        end
      end

      // Avalanche
      xxh64_pkg::ST_AV0: begin
        h_d     = h_q ^ (h_q >> xxh64_pkg::AVAL_SHIFT1);
        state_d = xxh64_pkg::ST_AV1;
      end

      xxh64_pkg::ST_AV1, xxh64_pkg::ST_AV3: begin
        mul_a = h_q;
        mul_b = (state_q == xxh64_pkg::ST_AV1) ? xxh64_pkg::PRIME2 : xxh64_pkg::PRIME3;
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          h_d      = mul_p;
          state_d  = (state_q == xxh64_pkg::ST_AV1) ? xxh64_pkg::ST_AV2 : xxh64_pkg::ST_AV4;
        end
      end

      xxh64_pkg::ST_AV2: begin
        h_d     = h_q ^ (h_q >> xxh64_pkg::AVAL_SHIFT2);
        state_d = xxh64_pkg::ST_AV3;
      end

      xxh64_pkg::ST_AV4: begin
        if (!out_valid_q || !out_stall_i) begin
          hash_d      = h_q ^ (h_q >> xxh64_pkg::AVAL_SHIFT3);
          out_valid_d = 1'b1;
          fill_d      = 2'd0;
          state_d     = xxh64_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = xxh64_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xxh64_pkg::ST_IDLE;
      ctx_q       <= xxh64_pkg::CTX_STRIPE;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= 64'h0;
      end
      fill_q      <= 2'd0;
      k_q         <= 2'd0;
      total_q     <= 64'h0;
      seed_q      <= 64'h0;
      seen_q      <= 1'b0;
      inmsg_q     <= 1'b0;
      last_q      <= 1'b0;
      left_q      <= 4'd0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      lane_q      <= lane_d;
      fill_q      <= fill_d;
      k_q         <= k_d;
      total_q     <= total_d;
      seed_q      <= seed_d;
      seen_q      <= seen_d;
      inmsg_q     <= inmsg_d;
      last_q      <= last_d;
      left_q      <= left_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    v_q    <= v_d;
    hash_q <= hash_d;
    if (buf_we) begin
      buf_q[buf_wa] <= wm;
    end
  end

  xxh64_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign in_stall_o  = (state_q != xxh64_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> issued_q) else $error("multiply result without request");
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q < 4'd8) else $error("tail byte count out of range");
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == xxh64_pkg::ST_AV4))
    else $error("hash word emitted outside the final step");

endmodule

`default_nettype wire

// ===== src/xxh64_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multi-cycle 64x64 multiplier, low 64 bits of the product.
// One 32x32 multiplier used in turn for the three partial products. No dependencies.

module xxh64_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  logic [63:0] a_q, b_q, prod_q, prod_d;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] mx, my;
  logic [63:0] mp;

  // Partial product select: lo*lo, then the two cross terms
  always_comb begin
    unique case (step_q)
      2'd0: begin
        mx = a_q[31:0];
        my = b_q[31:0];
      end
      2'd1: begin
        mx = a_q[63:32];
        my = b_q[31:0];
      end
      default: begin
        mx = a_q[31:0];
        my = b_q[63:32];
      end
    endcase
  end

  assign mp = mx * my;

  always_comb begin
    if (step_q == 2'd0) begin
      prod_d = mp;
    end else begin
      prod_d = prod_q + {mp[31:0], 32'h0};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          step_q <= 2'd0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  // Operands and accumulating product
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiply started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held longer than one cycle");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == 2'd2) |=> done_q) else $error("missing done");

endmodule

`default_nettype wire
